// ===== rtl/three_channel_interval_timer_defines.svh =====
// ----------------------------------------------------------------------------
// Three-channel interval timer: assertion macros
// Shared assertion forms, clocked on clk and disabled during rst.
// ----------------------------------------------------------------------------
`ifndef THREE_CHANNEL_INTERVAL_TIMER_DEFINES_SVH
`define THREE_CHANNEL_INTERVAL_TIMER_DEFINES_SVH

// Condition that holds at every clock edge out of reset.
`define TCIT_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("tcit: invariant violated");

// Consequence that holds in the cycle after the antecedent.
`define TCIT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tcit: next-cycle check failed");

`endif

// ===== rtl/tcit_pkg.sv =====
// ----------------------------------------------------------------------------
// Three-channel interval timer: package
// Types, codes and constants shared by the timer modules.
// ----------------------------------------------------------------------------
package tcit_pkg;

  localparam int NUM_CHANNELS_DEF = 3;
  localparam int TICK_WIDTH_DEF   = 32;
  localparam int QUEUE_DEPTH      = 2;

  localparam logic [16:0] FULL_COUNT = 17'h10000;

  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;

  localparam logic [1:0] PORT_CTRL    = 2'd3;
  localparam logic [1:0] SEL_READBACK = 2'd3;

  localparam logic [1:0] ACC_NONE = 2'd0;
  localparam logic [1:0] ACC_LSB  = 2'd1;
  localparam logic [1:0] ACC_MSB  = 2'd2;
  localparam logic [1:0] ACC_WORD = 2'd3;

  localparam logic [2:0] PH_NONE    = 3'd0;
  localparam logic [2:0] PH_LSB     = 3'd1;
  localparam logic [2:0] PH_MSB     = 3'd2;
  localparam logic [2:0] PH_WORD_LO = 3'd3;
  localparam logic [2:0] PH_WORD_HI = 3'd4;

  localparam logic [2:0] MODE_INT_ON_TC = 3'd0;
  localparam logic [2:0] MODE_ONE_SHOT  = 3'd1;
  localparam logic [2:0] MODE_RATE_GEN  = 3'd2;
  localparam logic [2:0] MODE_SQUARE    = 3'd3;
  localparam logic [2:0] MODE_SW_STROBE = 3'd4;
  localparam logic [2:0] MODE_HW_STROBE = 3'd5;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_READBACK,
    OP_LATCH,
    OP_MODE,
    OP_DATA_WR,
    OP_READ,
    OP_TICK
  } op_kind_t;

  typedef struct packed {
    op_kind_t    kind;
    logic [1:0]  ch;
    logic [7:0]  data;
  } queue_item_t;

endpackage

// ===== rtl/tcit_req_if.sv =====
// ----------------------------------------------------------------------------
// Three-channel interval timer: request channel
// Valid/ready channel carrying one port access or timer tick.
// ----------------------------------------------------------------------------
interface tcit_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [1:0] port;
  logic [7:0] wdata;

  modport source (output valid, output cmd, output port, output wdata, input ready);
  modport sink (input valid, input cmd, input port, input wdata, output ready);
endinterface

// ===== rtl/tcit_rsp_if.sv =====
// ----------------------------------------------------------------------------
// Three-channel interval timer: result channel
// Valid/ready channel carrying the read byte and the interrupt pulse.
// ----------------------------------------------------------------------------
interface tcit_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] rdata;
  logic       irq_pulse;

  modport source (output valid, output rdata, output irq_pulse, input ready);
  modport sink (input valid, input rdata, input irq_pulse, output ready);
endinterface

// ===== rtl/three_channel_interval_timer.sv =====
// A result is registered in the back end after its request has passed through the queue.
// Throughput: one request per cycle while the result channel is ready; each operation
// executes in the back end, fed from a two-entry queue behind the front end.
// Reset (synchronous): every channel reloads 65536 in mode 3 with no access
// mode set; elapsed time, latches and phases clear at once, no clearing pass.
// ----------------------------------------------------------------------------
// Three-channel interval timer: top level
// Front end, operation queue and back end of a three-channel interval timer.
// ----------------------------------------------------------------------------
module three_channel_interval_timer #(
  parameter int NUM_CHANNELS = tcit_pkg::NUM_CHANNELS_DEF,
  parameter int TICK_WIDTH   = tcit_pkg::TICK_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  tcit_req_if.sink   req,
  tcit_rsp_if.source rsp
);
  import tcit_pkg::*;

  logic        push_valid;
  logic        push_ready;
  queue_item_t push_item;
  logic        pop_valid;
  queue_item_t pop_item;
  logic        pop;

  tcit_front #(
    .NUM_CHANNELS(NUM_CHANNELS)
  ) u_front (
    .req       (req),
    .push_ready(push_ready),
    .push_valid(push_valid),
    .push_item (push_item)
  );

  tcit_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_valid(push_valid),
    .push_item (push_item),
    .push_ready(push_ready),
    .pop_valid (pop_valid),
    .pop_item  (pop_item),
    .pop       (pop)
  );

  tcit_back #(
    .NUM_CHANNELS(NUM_CHANNELS),
    .TICK_WIDTH  (TICK_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .item_valid(pop_valid),
    .item      (pop_item),
    .item_pop  (pop),
    .rsp       (rsp)
  );
endmodule

// ===== rtl/tcit_front.sv =====
// ----------------------------------------------------------------------------
// Three-channel interval timer: front end
// Accepts requests and classifies them into operations for the back end.
// ----------------------------------------------------------------------------
module tcit_front #(
  parameter int NUM_CHANNELS = tcit_pkg::NUM_CHANNELS_DEF
) (
  tcit_req_if.sink             req,
  input  logic                 push_ready,
  output logic                 push_valid,
  output tcit_pkg::queue_item_t push_item
);
  import tcit_pkg::*;

  logic [1:0] sel;

  assign sel        = req.wdata[7:6];
  assign push_valid = req.valid;
  assign req.ready  = push_ready;

  always_comb begin
    push_item.kind = OP_NONE;
    push_item.ch   = req.port;
    push_item.data = req.wdata;
    case (req.cmd)
      CMD_WRITE: begin
        if (req.port == PORT_CTRL) begin
          push_item.ch = sel;
          if (sel == SEL_READBACK) begin
            push_item.kind = OP_READBACK;
          end else if (int'(sel) < NUM_CHANNELS) begin
            push_item.kind = (req.wdata[5:4] == ACC_NONE) ? OP_LATCH : OP_MODE;
          end
        end else if (int'(req.port) < NUM_CHANNELS) begin
          push_item.kind = OP_DATA_WR;
        end
      end
      CMD_READ: begin
        if (req.port != PORT_CTRL && int'(req.port) < NUM_CHANNELS) begin
          push_item.kind = OP_READ;
        end
      end
      CMD_TICK: push_item.kind = OP_TICK;
      default:  push_item.kind = OP_NONE;
    endcase
  end
endmodule

// ===== rtl/tcit_queue.sv =====
// ----------------------------------------------------------------------------
// Three-channel interval timer: operation queue
// Short FIFO that decouples request acceptance from execution.
// ----------------------------------------------------------------------------
module tcit_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push_valid,
  input  tcit_pkg::queue_item_t push_item,
  output logic                  push_ready,
  output logic                  pop_valid,
  output tcit_pkg::queue_item_t pop_item,
  input  logic                  pop
);
  import tcit_pkg::*;
  `include "three_channel_interval_timer_defines.svh"

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNTW = $clog2(QUEUE_DEPTH + 1);

  queue_item_t entries [QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CNTW-1:0] count;
  logic            push;
  logic            do_pop;

  assign push_ready = (count != CNTW'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_item   = entries[rd_ptr];
  assign push       = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `TCIT_ASSERT_ALWAYS(a_count_bounded, count <= CNTW'(QUEUE_DEPTH))
  `TCIT_ASSERT_NEXT(a_fill_counts, push && !do_pop, count == $past(count) + 1'b1)
  `TCIT_ASSERT_NEXT(a_drain_counts, do_pop && !push, count == $past(count) - 1'b1)
endmodule

// ===== rtl/tcit_back.sv =====
// ----------------------------------------------------------------------------
// Three-channel interval timer: back end
// Holds the channel state, executes queued operations and registers results.
// ----------------------------------------------------------------------------
module tcit_back #(
  parameter int NUM_CHANNELS = tcit_pkg::NUM_CHANNELS_DEF,
  parameter int TICK_WIDTH   = tcit_pkg::TICK_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  input  tcit_pkg::queue_item_t item,
  output logic                  item_pop,
  tcit_rsp_if.source            rsp
);
  import tcit_pkg::*;
  `include "three_channel_interval_timer_defines.svh"

  localparam int CW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  logic [16:0]           reload     [NUM_CHANNELS];
  logic [TICK_WIDTH-1:0] elapsed    [NUM_CHANNELS];
  logic [16:0]           phase      [NUM_CHANNELS];
  logic [15:0]           held       [NUM_CHANNELS];
  logic [1:0]            hold_kind  [NUM_CHANNELS];
  logic                  st_held    [NUM_CHANNELS];
  logic [7:0]            st_byte    [NUM_CHANNELS];
  logic [2:0]            rphase     [NUM_CHANNELS];
  logic [2:0]            wphase     [NUM_CHANNELS];
  logic [7:0]            low_hold   [NUM_CHANNELS];
  logic [1:0]            acc        [NUM_CHANNELS];
  logic [2:0]            mode       [NUM_CHANNELS];
  logic                  bcd        [NUM_CHANNELS];
  logic [31:0]           last_edge;

  logic [16:0]           reload_next    [NUM_CHANNELS];
  logic [TICK_WIDTH-1:0] elapsed_next   [NUM_CHANNELS];
  logic [16:0]           phase_next     [NUM_CHANNELS];
  logic [15:0]           held_next      [NUM_CHANNELS];
  logic [1:0]            hold_kind_next [NUM_CHANNELS];
  logic                  st_held_next   [NUM_CHANNELS];
  logic [7:0]            st_byte_next   [NUM_CHANNELS];
  logic [2:0]            rphase_next    [NUM_CHANNELS];
  logic [2:0]            wphase_next    [NUM_CHANNELS];
  logic [7:0]            low_hold_next  [NUM_CHANNELS];
  logic [1:0]            acc_next       [NUM_CHANNELS];
  logic [2:0]            mode_next      [NUM_CHANNELS];
  logic                  bcd_next       [NUM_CHANNELS];
  logic [31:0]           last_edge_next;

  logic [15:0]           live  [NUM_CHANNELS];
  logic                  level [NUM_CHANNELS];

  logic                  out_valid;
  logic [7:0]            rdata_q;
  logic                  irq_q;
  logic [7:0]            rd_val;
  logic                  irq_val;
  logic                  exec;
  logic [CW-1:0]         ci;

  assign exec      = item_valid && (!out_valid || rsp.ready);
  assign item_pop  = exec;
  assign ci        = item.ch[CW-1:0];
  assign rsp.valid = out_valid;
  assign rsp.rdata = rdata_q;
  assign rsp.irq_pulse = irq_q;

  always_comb begin
    logic [17:0] p2;
    logic [17:0] m;
    logic [TICK_WIDTH-1:0] cw;
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      p2 = {phase[i], 1'b0};
      m  = (p2 >= {1'b0, reload[i]}) ? p2 - {1'b0, reload[i]} : p2;
      cw = TICK_WIDTH'(reload[i]);
      case (mode[i])
        MODE_INT_ON_TC, MODE_ONE_SHOT, MODE_SW_STROBE, MODE_HW_STROBE:
          live[i] = reload[i][15:0] - elapsed[i][15:0];
        MODE_SQUARE: live[i] = 16'(reload[i] - m[16:0]);
        default:     live[i] = 16'(reload[i] - phase[i]);
      endcase
      case (mode[i])
        MODE_ONE_SHOT: level[i] = elapsed[i] < cw;
        MODE_RATE_GEN: level[i] = (phase[i] == '0) && (elapsed[i] != '0);
        MODE_SQUARE:   level[i] = phase[i] < 17'((18'(reload[i]) + 18'd1) >> 1);
        MODE_SW_STROBE, MODE_HW_STROBE: level[i] = elapsed[i] == cw;
        default:       level[i] = elapsed[i] >= cw;
      endcase
    end
  end

  always_comb begin
    logic [15:0] v;
    logic        do_load;
    logic [TICK_WIDTH-1:0] dn;
    logic [16:0] p1;
    logic [31:0] diff;
    reload_next    = reload;
    elapsed_next   = elapsed;
    phase_next     = phase;
    held_next      = held;
    hold_kind_next = hold_kind;
    st_held_next   = st_held;
    st_byte_next   = st_byte;
    rphase_next    = rphase;
    wphase_next    = wphase;
    low_hold_next  = low_hold;
    acc_next       = acc;
    mode_next      = mode;
    bcd_next       = bcd;
    last_edge_next = last_edge;
    rd_val         = '0;
    irq_val        = 1'b0;
    v              = '0;
    do_load        = 1'b0;
    dn             = '0;
    p1             = '0;
    diff           = '0;
    case (item.kind)
      OP_READBACK: begin
        for (int i = 0; i < NUM_CHANNELS; i++) begin
          if (item.data[i+1]) begin
            if (!item.data[5] && hold_kind[i] == ACC_NONE) begin
              held_next[i]      = live[i];
              hold_kind_next[i] = acc[i];
            end
            if (!item.data[4] && !st_held[i]) begin
              st_byte_next[i] = {level[i], 1'b0, acc[i], mode[i], bcd[i]};
              st_held_next[i] = 1'b1;
            end
          end
        end
      end
      OP_LATCH: begin
        if (hold_kind[ci] == ACC_NONE) begin
          held_next[ci]      = live[ci];
          hold_kind_next[ci] = acc[ci];
        end
      end
      OP_MODE: begin
        acc_next[ci]    = item.data[5:4];
        rphase_next[ci] = {1'b0, item.data[5:4]};
        wphase_next[ci] = {1'b0, item.data[5:4]};
        mode_next[ci]   = item.data[3:1];
        bcd_next[ci]    = item.data[0];
      end
      OP_DATA_WR: begin
        case (wphase[ci])
          PH_LSB: begin
            v = {8'd0, item.data};
            do_load = 1'b1;
          end
          PH_MSB: begin
            v = {item.data, 8'd0};
            do_load = 1'b1;
          end
          PH_WORD_LO: begin
            low_hold_next[ci] = item.data;
            wphase_next[ci]   = PH_WORD_HI;
          end
          PH_WORD_HI: begin
            v = {item.data, low_hold[ci]};
            do_load = 1'b1;
            wphase_next[ci] = PH_WORD_LO;
          end
          default: do_load = 1'b0;
        endcase
        if (do_load) begin
          reload_next[ci]  = (v == '0) ? FULL_COUNT : {1'b0, v};
          elapsed_next[ci] = '0;
          phase_next[ci]   = '0;
          if (ci == '0) begin
            last_edge_next = '0;
          end
        end
      end
      OP_READ: begin
        if (st_held[ci]) begin
          st_held_next[ci] = 1'b0;
          rd_val = st_byte[ci];
        end else if (hold_kind[ci] != ACC_NONE) begin
          case (hold_kind[ci])
            ACC_LSB: begin
              hold_kind_next[ci] = ACC_NONE;
              rd_val = held[ci][7:0];
            end
            ACC_MSB: begin
              hold_kind_next[ci] = ACC_NONE;
              rd_val = held[ci][15:8];
            end
            default: begin
              hold_kind_next[ci] = ACC_MSB;
              rd_val = held[ci][7:0];
            end
          endcase
        end else begin
          case (rphase[ci])
            PH_LSB: rd_val = live[ci][7:0];
            PH_MSB: rd_val = live[ci][15:8];
            PH_WORD_LO: begin
              rphase_next[ci] = PH_WORD_HI;
              rd_val = live[ci][7:0];
            end
            PH_WORD_HI: begin
              rphase_next[ci] = PH_WORD_LO;
              rd_val = live[ci][15:8];
            end
            default: rd_val = '0;
          endcase
        end
      end
      OP_TICK: begin
        for (int i = 0; i < NUM_CHANNELS; i++) begin
          dn = elapsed[i] + 1'b1;
          p1 = phase[i] + 1'b1;
          elapsed_next[i] = dn;
          phase_next[i]   = (dn == '0 || p1 == reload[i]) ? '0 : p1;
        end
        dn = elapsed[0] + 1'b1;
        if (mode[0] == MODE_RATE_GEN || mode[0] == MODE_SQUARE) begin
          diff = last_edge + 32'(reload[0]) - 32'(dn);
          if (diff[31]) begin
            irq_val        = 1'b1;
            last_edge_next = last_edge + 32'(reload[0]);
          end
        end
      end
      default: rd_val = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        reload[i]    <= FULL_COUNT;
        elapsed[i]   <= '0;
        phase[i]     <= '0;
        held[i]      <= '0;
        hold_kind[i] <= ACC_NONE;
        st_held[i]   <= 1'b0;
        st_byte[i]   <= '0;
        rphase[i]    <= PH_NONE;
        wphase[i]    <= PH_NONE;
        low_hold[i]  <= '0;
        acc[i]       <= ACC_NONE;
        mode[i]      <= MODE_SQUARE;
        bcd[i]       <= 1'b0;
      end
      last_edge <= '0;
      out_valid <= 1'b0;
      rdata_q   <= '0;
      irq_q     <= 1'b0;
    end else begin
      if (exec) begin
        reload    <= reload_next;
        elapsed   <= elapsed_next;
        phase     <= phase_next;
        held      <= held_next;
        hold_kind <= hold_kind_next;
        st_held   <= st_held_next;
        st_byte   <= st_byte_next;
        rphase    <= rphase_next;
        wphase    <= wphase_next;
        low_hold  <= low_hold_next;
        acc       <= acc_next;
        mode      <= mode_next;
        bcd       <= bcd_next;
        last_edge <= last_edge_next;
        rdata_q   <= rd_val;
        irq_q     <= irq_val;
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `TCIT_ASSERT_ALWAYS(a_phase_below_period, phase[0] < reload[0])
  `TCIT_ASSERT_NEXT(a_irq_only_on_tick, exec && item.kind != OP_TICK, !irq_q)
  `TCIT_ASSERT_NEXT(a_rdata_only_on_read, exec && item.kind != OP_READ, rdata_q == '0)
endmodule

// ===== tb/sv/three_channel_interval_timer_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Three-channel interval timer: testbench
// Drives port writes, port reads and timer ticks into the timer, predicts
// every result from a behavioural model of the three channels and compares
// each returned byte and interrupt pulse with the oldest prediction.
// ----------------------------------------------------------------------------
module three_channel_interval_timer_tb;
  import tcit_pkg::*;

  typedef struct packed {
    logic [1:0] cmd;
    logic [1:0] port;
    logic [7:0] wdata;
    logic       known;
    logic [7:0] rdata;
    logic       irq;
  } stim_row_t;

  typedef struct packed {
    logic [7:0] rdata;
    logic       irq;
  } timer_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  tcit_req_if req ();
  tcit_rsp_if rsp ();

  three_channel_interval_timer dut (
    .clk (clk),
    .rst (rst),
    .req (req.sink),
    .rsp (rsp.source)
  );

  always #5 clk = ~clk;

  logic [16:0] reload_q [3];
  logic [31:0] elapsed_q [3];
  logic [31:0] edge_q [3];
  logic [15:0] held_cnt [3];
  logic [2:0]  held_kind [3];
  logic        stat_held [3];
  logic [7:0]  stat_byte [3];
  logic [2:0]  rd_phase [3];
  logic [2:0]  wr_phase [3];
  logic [7:0]  low_hold [3];
  logic [1:0]  acc_kind [3];
  logic [2:0]  mode_q [3];
  logic        bcd_q [3];

  timer_result_t expected_results [$];
  int  fail_count = 0;
  int  sent_count = 0;
  bit  quiet_rx = 0;
  bit  quiet_tx = 0;

  function automatic logic [15:0] live_count(int ch);
    logic [31:0] d;
    logic [31:0] c;
    d = elapsed_q[ch];
    c = {15'd0, reload_q[ch]};
    case (mode_q[ch])
      3'd0, 3'd1, 3'd4, 3'd5: live_count = 16'(c - d);
      3'd3: live_count = 16'(c - ((2 * (d % c)) % c));
      default: live_count = 16'(c - (d % c));
    endcase
  endfunction

  function automatic logic out_level(int ch);
    logic [31:0] d;
    logic [31:0] c;
    d = elapsed_q[ch];
    c = {15'd0, reload_q[ch]};
    case (mode_q[ch])
      3'd1: out_level = d < c;
      3'd2: out_level = (d % c) == 0 && d != 0;
      3'd3: out_level = (d % c) < ((c + 1) >> 1);
      3'd4, 3'd5: out_level = d == c;
      default: out_level = d >= c;
    endcase
  endfunction

  function automatic void reset_timer_model();
    for (int ch = 0; ch < 3; ch++) begin
      reload_q[ch] = FULL_COUNT;
      elapsed_q[ch] = '0;
      edge_q[ch] = '0;
      held_cnt[ch] = '0;
      held_kind[ch] = '0;
      stat_held[ch] = 1'b0;
      stat_byte[ch] = '0;
      rd_phase[ch] = PH_NONE;
      wr_phase[ch] = PH_NONE;
      low_hold[ch] = '0;
      acc_kind[ch] = ACC_NONE;
      mode_q[ch] = MODE_SQUARE;
      bcd_q[ch] = 1'b0;
    end
  endfunction

  function automatic void load_reload(int ch, logic [15:0] v);
    reload_q[ch] = (v == 0) ? FULL_COUNT : {1'b0, v};
    elapsed_q[ch] = '0;
    edge_q[ch] = '0;
  endfunction

  function automatic void latch_count(int ch);
    if (held_kind[ch] == 0) begin
      held_cnt[ch] = live_count(ch);
      held_kind[ch] = {1'b0, acc_kind[ch]};
    end
  endfunction

  function automatic timer_result_t predict_timer(logic [1:0] cmd, logic [1:0] port,
                                                  logic [7:0] v);
    timer_result_t r;
    int ch;
    logic [15:0] cnt;
    logic [31:0] diff;
    r = '0;
    ch = port;
    if (cmd == CMD_WRITE && port == PORT_CTRL) begin
      if (v[7:6] == SEL_READBACK) begin
        for (int k = 0; k < 3; k++) begin
          if (v[k + 1]) begin
            if (!v[5]) latch_count(k);
            if (!v[4] && !stat_held[k]) begin
              stat_byte[k] = {out_level(k), 1'b0, acc_kind[k], mode_q[k], bcd_q[k]};
              stat_held[k] = 1'b1;
            end
          end
        end
      end else if (v[5:4] == ACC_NONE) begin
        latch_count(v[7:6]);
      end else begin
        acc_kind[v[7:6]] = v[5:4];
        rd_phase[v[7:6]] = {1'b0, v[5:4]};
        wr_phase[v[7:6]] = {1'b0, v[5:4]};
        mode_q[v[7:6]] = v[3:1];
        bcd_q[v[7:6]] = v[0];
      end
    end else if (cmd == CMD_WRITE) begin
      case (wr_phase[ch])
        PH_LSB: load_reload(ch, {8'd0, v});
        PH_MSB: load_reload(ch, {v, 8'd0});
        PH_WORD_LO: begin
          low_hold[ch] = v;
          wr_phase[ch] = PH_WORD_HI;
        end
        PH_WORD_HI: begin
          load_reload(ch, {v, low_hold[ch]});
          wr_phase[ch] = PH_WORD_LO;
        end
        default: ;
      endcase
    end else if (cmd == CMD_READ && port != PORT_CTRL) begin
      if (stat_held[ch]) begin
        stat_held[ch] = 1'b0;
        r.rdata = stat_byte[ch];
      end else if (held_kind[ch] != 0) begin
        case (held_kind[ch])
          3'd1: begin
            held_kind[ch] = 0;
            r.rdata = held_cnt[ch][7:0];
          end
          3'd2: begin
            held_kind[ch] = 0;
            r.rdata = held_cnt[ch][15:8];
          end
          default: begin
            held_kind[ch] = 3'd2;
            r.rdata = held_cnt[ch][7:0];
          end
        endcase
      end else begin
        cnt = live_count(ch);
        case (rd_phase[ch])
          PH_LSB: r.rdata = cnt[7:0];
          PH_MSB: r.rdata = cnt[15:8];
          PH_WORD_LO: begin
            rd_phase[ch] = PH_WORD_HI;
            r.rdata = cnt[7:0];
          end
          PH_WORD_HI: begin
            rd_phase[ch] = PH_WORD_LO;
            r.rdata = cnt[15:8];
          end
          default: r.rdata = 8'd0;
        endcase
      end
    end else if (cmd == CMD_TICK) begin
      for (int k = 0; k < 3; k++) elapsed_q[k] = elapsed_q[k] + 1;
      if (mode_q[0] == MODE_RATE_GEN || mode_q[0] == MODE_SQUARE) begin
        diff = edge_q[0] + {15'd0, reload_q[0]} - elapsed_q[0];
        if (diff[31]) begin
          edge_q[0] = edge_q[0] + {15'd0, reload_q[0]};
          r.irq = 1'b1;
        end
      end
    end
    return r;
  endfunction

  task automatic send_request(logic [1:0] cmd, logic [1:0] port, logic [7:0] v);
    while (!quiet_tx && $urandom_range(99) < 21) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid <= 1'b1;
    req.cmd <= cmd;
    req.port <= port;
    req.wdata <= v;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    expected_results.push_back(predict_timer(cmd, port, v));
    sent_count++;
  endtask

  task automatic send_checked(stim_row_t row);
    timer_result_t p;
    send_request(row.cmd, row.port, row.wdata);
    p = expected_results[$];
    if (row.known && (p.rdata != row.rdata || p.irq != row.irq)) begin
      fail_count++;
      if (fail_count <= 10)
        $display("table row disagrees: cmd %0d port %0d expected %h/%0d, predicted %h/%0d",
                 row.cmd, row.port, row.rdata, row.irq, p.rdata, p.irq);
    end
  endtask

  task automatic send_random_sequence();
    int ch;
    int kind;
    ch = $urandom_range(2);
    kind = $urandom_range(9);
    case (kind)
      0, 1: begin
        send_request(CMD_WRITE, PORT_CTRL,
                     {2'(ch), 2'($urandom_range(1, 3)), 3'($urandom), 1'($urandom)});
        send_request(CMD_WRITE, 2'(ch), 8'($urandom_range(0, 12)));
        send_request(CMD_WRITE, 2'(ch), 8'($urandom_range(0, 2)));
      end
      2: send_request(CMD_WRITE, PORT_CTRL, {2'(ch), 6'($urandom) & 6'h0f});
      3: send_request(CMD_WRITE, PORT_CTRL, {2'b11, 6'($urandom)});
      4, 5: repeat ($urandom_range(1, 3)) send_request(CMD_READ, 2'(ch), 8'($urandom));
      6, 7, 8: repeat ($urandom_range(1, 8)) send_request(CMD_TICK, 2'($urandom), 8'($urandom));
      default: send_request(2'($urandom), 2'($urandom), 8'($urandom));
    endcase
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      rsp.ready <= quiet_rx || ($urandom_range(99) >= 21);
      if (rsp.valid && rsp.ready) begin
        if (expected_results.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result %h/%0d", rsp.rdata, rsp.irq_pulse);
        end else begin
          timer_result_t e;
          e = expected_results.pop_front();
          if (e.rdata !== rsp.rdata || e.irq !== rsp.irq_pulse) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: expected rdata %h irq %0d, got rdata %h irq %0d",
                       e.rdata, e.irq, rsp.rdata, rsp.irq_pulse);
          end
        end
      end
    end
  end

  initial begin
    #20ms;
    $display("** three_channel_interval_timer: FAILED **");
    $finish;
  end

  initial begin
    stim_row_t rows [$];
    req.valid = 1'b0;
    req.cmd = CMD_TICK;
    req.port = '0;
    req.wdata = '0;
    rsp.ready = 1'b0;
    reset_timer_model();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    rows = '{
      '{CMD_READ, 2'd0, 8'h00, 1'b1, 8'h00, 1'b0},
      '{CMD_READ, PORT_CTRL, 8'hff, 1'b1, 8'h00, 1'b0},
      '{CMD_WRITE, 2'd1, 8'hff, 1'b1, 8'h00, 1'b0},
      '{2'd3, 2'd2, 8'hff, 1'b1, 8'h00, 1'b0},
      '{CMD_WRITE, PORT_CTRL, 8'hee, 1'b1, 8'h00, 1'b0},
      '{CMD_READ, 2'd0, 8'h00, 1'b1, 8'h86, 1'b0},
      '{CMD_WRITE, PORT_CTRL, 8'h34, 1'b0, 8'h00, 1'b0},
      '{CMD_WRITE, 2'd0, 8'h03, 1'b0, 8'h00, 1'b0},
      '{CMD_WRITE, 2'd0, 8'h00, 1'b0, 8'h00, 1'b0},
      '{CMD_TICK, 2'd0, 8'h00, 1'b0, 8'h00, 1'b0},
      '{CMD_TICK, 2'd3, 8'hff, 1'b0, 8'h00, 1'b0},
      '{CMD_TICK, 2'd1, 8'h00, 1'b0, 8'h00, 1'b0},
      '{CMD_TICK, 2'd2, 8'h00, 1'b0, 8'h00, 1'b0},
      '{CMD_WRITE, PORT_CTRL, 8'h00, 1'b0, 8'h00, 1'b0},
      '{CMD_READ, 2'd0, 8'h00, 1'b0, 8'h00, 1'b0},
      '{CMD_READ, 2'd0, 8'h00, 1'b0, 8'h00, 1'b0},
      '{CMD_WRITE, PORT_CTRL, 8'h5b, 1'b0, 8'h00, 1'b0},
      '{CMD_WRITE, 2'd1, 8'h00, 1'b0, 8'h00, 1'b0},
      '{CMD_READ, 2'd1, 8'h00, 1'b0, 8'h00, 1'b0},
      '{CMD_WRITE, PORT_CTRL, 8'ha1, 1'b0, 8'h00, 1'b0},
      '{CMD_WRITE, 2'd2, 8'h80, 1'b0, 8'h00, 1'b0},
      '{CMD_WRITE, PORT_CTRL, 8'hce, 1'b0, 8'h00, 1'b0},
      '{CMD_READ, 2'd2, 8'h00, 1'b0, 8'h00, 1'b0},
      '{CMD_READ, 2'd2, 8'h00, 1'b0, 8'h00, 1'b0},
      '{CMD_READ, 2'd2, 8'h00, 1'b0, 8'h00, 1'b0}
    };
    @(posedge clk);
    foreach (rows[i]) send_checked(rows[i]);
    while (sent_count < 950) begin
      quiet_tx = (sent_count >= 300 && sent_count < 450);
      quiet_rx = quiet_tx;
      send_random_sequence();
    end
    req.valid <= 1'b0;
    quiet_rx = 1'b1;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("** three_channel_interval_timer: PASSED **");
    end else begin
      $display("** three_channel_interval_timer: FAILED **");
    end
    $finish;
  end
endmodule
